/* hdl/bdp_pkg.sv */
// ---------------------------------------------------------------------------
// bdp_pkg
// Shared constants, codes and types of the bipolar distance prune unit.
// ---------------------------------------------------------------------------
`default_nettype none

package bdp_pkg;

   // table geometry
   localparam int MAX_POINTS = 1024;
   localparam int NUM_PIVOTS = 16;
   localparam int POINT_W    = $clog2(MAX_POINTS);
   localparam int PIVOT_W    = $clog2(NUM_PIVOTS);
   localparam int DIST_W     = 32;
   localparam int FRAC_W     = 16;

   // arithmetic widths
   localparam int MAG_W       = DIST_W + 1;        // |a1 + g - a2|
   localparam int PROD_W      = 2 * MAG_W;
   localparam int QUOT_W      = 41;
   localparam logic [QUOT_W-1:0] QUOT_CAP = {1'b1, {(QUOT_W-1){1'b0}}};
   localparam int FIXED_W     = 44;
   localparam int ROOT_W      = 32;
   localparam int RAD_W       = 2 * ROOT_W;
   localparam int SAME_ROOT_W = 24;

   // divider: quotient bits developed, bits per stage
   localparam int DIV_Q_W    = 44;
   localparam int DIV_STEPS  = 4;
   localparam int DIV_STAGES = DIV_Q_W / DIV_STEPS;
   localparam int DIV_LAT    = DIV_STAGES + 1;

   // square root: root bits per stage
   localparam int SQRT_STEPS = 4;
   localparam int SQRT_LAT   = ROOT_W / SQRT_STEPS;

   // pipeline taps, counted from the table read register
   localparam int T_SAME_SQ      = SQRT_LAT + 3;
   localparam int T_DIV_OUT      = DIV_LAT + 2;
   localparam int T_ROOT         = DIV_LAT + SQRT_LAT + 4;
   localparam int RESULT_LATENCY = T_ROOT + 3;

   typedef enum logic [1:0] {
      OP_SET_PIVOT      = 2'd0,
      OP_SET_POINT_DIST = 2'd1,
      OP_SET_PIVOT_DIST = 2'd2,
      OP_QUERY          = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      VERDICT_WITHIN    = 2'd0,
      VERDICT_EXCEEDS   = 2'd1,
      VERDICT_UNDECIDED = 2'd2
   } verdict_type;

   typedef struct packed {
      logic              valid;
      logic              same;
      logic [DIST_W-1:0] rsq;
      logic [DIST_W-1:0] a1;
      logic [DIST_W-1:0] a2;
      logic [DIST_W-1:0] b1;
      logic [DIST_W-1:0] b2;
      logic [DIST_W-1:0] g;
   } front_out_type;

endpackage

`default_nettype wire

/* hdl/bdp_divider.sv */
// ---------------------------------------------------------------------------
// bdp_divider
// Pipelined restoring divider: floor(dividend / divisor) with overflow flag
// when the quotient does not fit DIV_Q_W bits.
// ---------------------------------------------------------------------------
`default_nettype none

module bdp_divider (
   input  wire logic                         clock,
   input  wire logic [bdp_pkg::PROD_W-1:0]   dividend,
   input  wire logic [bdp_pkg::DIST_W-1:0]   divisor,
   output logic                              overflow,
   output logic [bdp_pkg::DIV_Q_W-1:0]       quotient
);

   localparam int HI_W = bdp_pkg::PROD_W - bdp_pkg::DIV_Q_W;

   typedef struct packed {
      logic                          ovf;
      logic [bdp_pkg::DIST_W-1:0]    rem;
      logic [bdp_pkg::DIV_Q_W-1:0]   low;
      logic [bdp_pkg::DIST_W-1:0]    dvs;
   } div_state_type;

   div_state_type div_ff [0:bdp_pkg::DIV_STAGES];
   div_state_type div_in [0:bdp_pkg::DIV_STAGES];

   function automatic div_state_type div_step(div_state_type s);
      logic [bdp_pkg::DIST_W:0] rem_shift;
      logic [bdp_pkg::DIST_W:0] diff;
      div_state_type            r;
      rem_shift = {s.rem, s.low[bdp_pkg::DIV_Q_W-1]};
      diff      = rem_shift - {1'b0, s.dvs};
      r         = s;
      if (rem_shift >= {1'b0, s.dvs}) begin
         r.rem = diff[bdp_pkg::DIST_W-1:0];
         r.low = {s.low[bdp_pkg::DIV_Q_W-2:0], 1'b1};
      end else begin
         r.rem = rem_shift[bdp_pkg::DIST_W-1:0];
         r.low = {s.low[bdp_pkg::DIV_Q_W-2:0], 1'b0};
      end
      return r;
   endfunction

   always_comb begin
      div_state_type s;
      // head stage: flag a quotient too wide, seed the partial remainder
      div_in[0].ovf = {{(bdp_pkg::DIST_W-HI_W){1'b0}},
                       dividend[bdp_pkg::PROD_W-1:bdp_pkg::DIV_Q_W]} >= divisor;
      div_in[0].rem = {{(bdp_pkg::DIST_W-HI_W){1'b0}},
                       dividend[bdp_pkg::PROD_W-1:bdp_pkg::DIV_Q_W]};
      div_in[0].low = dividend[bdp_pkg::DIV_Q_W-1:0];
      div_in[0].dvs = divisor;
      for (int i = 1; i <= bdp_pkg::DIV_STAGES; i++) begin
         s = div_ff[i-1];
         for (int k = 0; k < bdp_pkg::DIV_STEPS; k++) begin
            s = div_step(s);
         end
         div_in[i] = s;
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
   end

   assign overflow = div_ff[bdp_pkg::DIV_STAGES].ovf;
   assign quotient = div_ff[bdp_pkg::DIV_STAGES].low;

endmodule

`default_nettype wire

/* hdl/bdp_isqrt.sv */
// ---------------------------------------------------------------------------
// bdp_isqrt
// Pipelined floored integer square root, four root bits per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module bdp_isqrt (
   input  wire logic                        clock,
   input  wire logic [bdp_pkg::RAD_W-1:0]   radicand,
   output logic [bdp_pkg::ROOT_W-1:0]       root
);

   localparam int REM_W = bdp_pkg::ROOT_W + 2;

   typedef struct packed {
      logic [bdp_pkg::RAD_W-1:0]  rad;
      logic [REM_W-1:0]           rem;
      logic [bdp_pkg::ROOT_W-1:0] root;
   } sqrt_state_type;

   sqrt_state_type sq_ff [0:bdp_pkg::SQRT_LAT-1];
   sqrt_state_type sq_in [0:bdp_pkg::SQRT_LAT-1];

   function automatic sqrt_state_type sqrt_step(sqrt_state_type s);
      logic [REM_W+1:0] rem_shift;
      logic [REM_W+1:0] trial;
      logic [REM_W+1:0] diff;
      sqrt_state_type   r;
      rem_shift = {s.rem, s.rad[bdp_pkg::RAD_W-1:bdp_pkg::RAD_W-2]};
      trial     = {2'b00, s.root, 2'b01};
      diff      = rem_shift - trial;
      r.rad     = {s.rad[bdp_pkg::RAD_W-3:0], 2'b00};
      if (rem_shift >= trial) begin
         r.rem  = diff[REM_W-1:0];
         r.root = {s.root[bdp_pkg::ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = rem_shift[REM_W-1:0];
         r.root = {s.root[bdp_pkg::ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

   always_comb begin
      sqrt_state_type s;
      for (int i = 0; i < bdp_pkg::SQRT_LAT; i++) begin
         if (i == 0) begin
            s.rad  = radicand;
            s.rem  = '0;
            s.root = '0;
         end else begin
            s = sq_ff[i-1];
         end
         for (int k = 0; k < bdp_pkg::SQRT_STEPS; k++) begin
            s = sqrt_step(s);
         end
         sq_in[i] = s;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff <= sq_in;
   end

   assign root = sq_ff[bdp_pkg::SQRT_LAT-1].root;

endmodule

`default_nettype wire

/* hdl/bdp_front.sv */
// ---------------------------------------------------------------------------
// bdp_front
// Table stages: pivot lookup, then point-pivot and pivot-pivot lookups.
// Each table is written in the stage where it is read, keeping item order.
// ---------------------------------------------------------------------------
`default_nettype none

module bdp_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire bdp_pkg::op_type               op,
   input  wire logic [bdp_pkg::POINT_W-1:0]   point_index,
   input  wire logic [bdp_pkg::POINT_W-1:0]   other_point_index,
   input  wire logic [bdp_pkg::PIVOT_W-1:0]   pivot_index,
   input  wire logic [bdp_pkg::PIVOT_W-1:0]   other_pivot_index,
   input  wire logic [bdp_pkg::DIST_W-1:0]    load_value,
   input  wire logic [bdp_pkg::DIST_W-1:0]    radius_sq,
   output bdp_pkg::front_out_type             front_out
);

   localparam int PP_DEPTH = bdp_pkg::MAX_POINTS * bdp_pkg::NUM_PIVOTS;
   localparam int GG_DEPTH = bdp_pkg::NUM_PIVOTS * bdp_pkg::NUM_PIVOTS;

   logic [bdp_pkg::PIVOT_W-1:0] pivot_mem  [bdp_pkg::MAX_POINTS];
   logic [bdp_pkg::DIST_W-1:0]  dist_a_mem [PP_DEPTH];
   logic [bdp_pkg::DIST_W-1:0]  dist_b_mem [PP_DEPTH];
   logic [bdp_pkg::DIST_W-1:0]  gap_mem    [GG_DEPTH];

   logic                        s1_valid_ff;
   bdp_pkg::op_type             s1_op_ff;
   logic [bdp_pkg::POINT_W-1:0] s1_point_ff;
   logic [bdp_pkg::POINT_W-1:0] s1_other_ff;
   logic [bdp_pkg::PIVOT_W-1:0] s1_pivot_ff;
   logic [bdp_pkg::PIVOT_W-1:0] s1_other_pivot_ff;
   logic [bdp_pkg::DIST_W-1:0]  s1_value_ff;
   logic [bdp_pkg::DIST_W-1:0]  s1_radius_ff;
   logic [bdp_pkg::PIVOT_W-1:0] s1_c1_ff;
   logic [bdp_pkg::PIVOT_W-1:0] s1_c2_ff;

   logic                        out_valid_ff;
   bdp_pkg::front_out_type      out_data_ff;

   logic                        s1_is_query;

   assign s1_is_query = s1_valid_ff && (s1_op_ff == bdp_pkg::OP_QUERY);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         out_valid_ff <= s1_is_query;
      end
   end

   // stage 1: pivot table
   always_ff @(posedge clock) begin
      if (accept && op == bdp_pkg::OP_SET_PIVOT) begin
         pivot_mem[point_index] <= pivot_index;
      end
      s1_c1_ff          <= pivot_mem[point_index];
      s1_c2_ff          <= pivot_mem[other_point_index];
      s1_op_ff          <= op;
      s1_point_ff       <= point_index;
      s1_other_ff       <= other_point_index;
      s1_pivot_ff       <= pivot_index;
      s1_other_pivot_ff <= other_pivot_index;
      s1_value_ff       <= load_value;
      s1_radius_ff      <= radius_sq;
   end

   // stage 2: distance tables, two copies give four reads per cycle
   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_op_ff == bdp_pkg::OP_SET_POINT_DIST) begin
         dist_a_mem[{s1_point_ff, s1_pivot_ff}] <= s1_value_ff;
         dist_b_mem[{s1_point_ff, s1_pivot_ff}] <= s1_value_ff;
      end
      if (s1_valid_ff && s1_op_ff == bdp_pkg::OP_SET_PIVOT_DIST) begin
         gap_mem[{s1_pivot_ff, s1_other_pivot_ff}] <= s1_value_ff;
      end
      out_data_ff.a1   <= dist_a_mem[{s1_point_ff, s1_c1_ff}];
      out_data_ff.a2   <= dist_a_mem[{s1_point_ff, s1_c2_ff}];
      out_data_ff.b1   <= dist_b_mem[{s1_other_ff, s1_c1_ff}];
      out_data_ff.b2   <= dist_b_mem[{s1_other_ff, s1_c2_ff}];
      out_data_ff.g    <= gap_mem[{s1_c1_ff, s1_c2_ff}];
      out_data_ff.same <= (s1_c1_ff == s1_c2_ff);
      out_data_ff.rsq  <= s1_radius_ff;
      out_data_ff.valid <= 1'b0;
   end

   always_comb begin
      front_out       = out_data_ff;
      front_out.valid = out_valid_ff;
   end

endmodule

`default_nettype wire

/* hdl/bdp_math.sv */
// ---------------------------------------------------------------------------
// bdp_math
// Bound arithmetic: dot terms, products, three dividers, perpendicular root
// and the same-pivot root difference, merged into one verdict.
// ---------------------------------------------------------------------------
`default_nettype none

module bdp_math (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire bdp_pkg::front_out_type  front_out,
   output logic                         result_valid,
   output bdp_pkg::verdict_type         result_verdict
);

   localparam int SUM_W = bdp_pkg::DIST_W + 3;

   typedef struct packed {
      logic                                same;
      logic                                gap_zero;
      logic                                par_neg;
      logic                                same_exceeds;
      logic [bdp_pkg::DIST_W-1:0]          rsq;
      logic [bdp_pkg::DIST_W-1:0]          a1;
      logic [bdp_pkg::DIST_W-1:0]          b1;
      logic signed [bdp_pkg::FIXED_W-1:0]  fixed;
   } side_type;

   logic     valid_ff [1:bdp_pkg::T_ROOT];
   side_type side_ff  [1:bdp_pkg::T_ROOT];
   side_type side_in  [1:bdp_pkg::T_ROOT];

   // dot terms
   logic signed [SUM_W-1:0]     sa_s, sb_s, sa_abs, sb_abs;
   logic [bdp_pkg::MAG_W-1:0]   sa_mag_ff, sb_mag_ff;
   logic [bdp_pkg::DIST_W-1:0]  g1_ff, g2_ff;
   logic [bdp_pkg::PROD_W-1:0]  prod_ab_ff, prod_aa_ff, prod_bb_ff;

   // divider results
   logic                        ovf_ab, ovf_aa, ovf_bb;
   logic [bdp_pkg::DIV_Q_W-1:0] q_ab, q_aa, q_bb;
   logic [bdp_pkg::QUOT_W-1:0]  m_ab, m_aa, m_bb;
   logic [bdp_pkg::DIST_W-1:0]  ra_ff, rb_ff;
   logic [bdp_pkg::RAD_W-1:0]   rprod_ff;
   logic signed [bdp_pkg::FIXED_W-1:0] fixed_val, par_term;
   logic [bdp_pkg::ROOT_W-1:0]  perp_root;

   // same-pivot path
   logic [bdp_pkg::ROOT_W-1:0]      root_a, root_b;
   logic [bdp_pkg::SAME_ROOT_W-1:0] same_diff_ff;
   logic [2*bdp_pkg::SAME_ROOT_W-1:0] same_sq_ff;
   logic                            same_exceeds;

   // final compare
   logic signed [bdp_pkg::FIXED_W-1:0] perp, rsq_s;
   side_type                           fin;

   function automatic logic [bdp_pkg::QUOT_W-1:0] saturate(
      input logic ovf, input logic [bdp_pkg::DIV_Q_W-1:0] q);
      if (ovf || q > {{(bdp_pkg::DIV_Q_W-bdp_pkg::QUOT_W){1'b0}}, bdp_pkg::QUOT_CAP}) begin
         return bdp_pkg::QUOT_CAP;
      end
      return q[bdp_pkg::QUOT_W-1:0];
   endfunction

   function automatic logic [bdp_pkg::DIST_W-1:0] clamp_sub(
      input logic [bdp_pkg::DIST_W-1:0] a, input logic [bdp_pkg::QUOT_W-1:0] m);
      logic [bdp_pkg::QUOT_W-1:0] a_ext;
      logic [bdp_pkg::QUOT_W-1:0] diff;
      a_ext = {{(bdp_pkg::QUOT_W-bdp_pkg::DIST_W){1'b0}}, a};
      diff  = a_ext - m;
      if (m >= a_ext) begin
         return '0;
      end
      return diff[bdp_pkg::DIST_W-1:0];
   endfunction

   // t0 -> t1: dot terms and their signs
   always_comb begin
      sa_s = $signed({3'b000, front_out.a1}) + $signed({3'b000, front_out.g})
           - $signed({3'b000, front_out.a2});
      sb_s = $signed({3'b000, front_out.b1}) + $signed({3'b000, front_out.g})
           - $signed({3'b000, front_out.b2});
      sa_abs = sa_s[SUM_W-1] ? -sa_s : sa_s;
      sb_abs = sb_s[SUM_W-1] ? -sb_s : sb_s;
   end

   always_ff @(posedge clock) begin
      sa_mag_ff  <= sa_abs[bdp_pkg::MAG_W-1:0];
      sb_mag_ff  <= sb_abs[bdp_pkg::MAG_W-1:0];
      g1_ff      <= front_out.g;
      // t1 -> t2: full-width products
      prod_ab_ff <= {{bdp_pkg::MAG_W{1'b0}}, sa_mag_ff} * {{bdp_pkg::MAG_W{1'b0}}, sb_mag_ff};
      prod_aa_ff <= {{bdp_pkg::MAG_W{1'b0}}, sa_mag_ff} * {{bdp_pkg::MAG_W{1'b0}}, sa_mag_ff};
      prod_bb_ff <= {{bdp_pkg::MAG_W{1'b0}}, sb_mag_ff} * {{bdp_pkg::MAG_W{1'b0}}, sb_mag_ff};
      g2_ff      <= g1_ff;
   end

   // halve or quarter the product so each divider sees the gap itself
   bdp_divider u_div_ab (
      .clock    (clock),
      .dividend ({1'b0, prod_ab_ff[bdp_pkg::PROD_W-1:1]}),
      .divisor  (g2_ff),
      .overflow (ovf_ab),
      .quotient (q_ab)
   );

   bdp_divider u_div_aa (
      .clock    (clock),
      .dividend ({2'b00, prod_aa_ff[bdp_pkg::PROD_W-1:2]}),
      .divisor  (g2_ff),
      .overflow (ovf_aa),
      .quotient (q_aa)
   );

   bdp_divider u_div_bb (
      .clock    (clock),
      .dividend ({2'b00, prod_bb_ff[bdp_pkg::PROD_W-1:2]}),
      .divisor  (g2_ff),
      .overflow (ovf_bb),
      .quotient (q_bb)
   );

   // divider output: saturate, clamp the perpendicular terms, form fixed part
   always_comb begin
      m_ab     = saturate(ovf_ab, q_ab);
      m_aa     = saturate(ovf_aa, q_aa);
      m_bb     = saturate(ovf_bb, q_bb);
      par_term = $signed({{(bdp_pkg::FIXED_W-bdp_pkg::QUOT_W){1'b0}}, m_ab});
      fixed_val = $signed({{(bdp_pkg::FIXED_W-bdp_pkg::DIST_W){1'b0}},
                           side_ff[bdp_pkg::T_DIV_OUT].a1})
                + $signed({{(bdp_pkg::FIXED_W-bdp_pkg::DIST_W){1'b0}},
                           side_ff[bdp_pkg::T_DIV_OUT].b1})
                + (side_ff[bdp_pkg::T_DIV_OUT].par_neg ? par_term : -par_term);
   end

   always_ff @(posedge clock) begin
      ra_ff    <= clamp_sub(side_ff[bdp_pkg::T_DIV_OUT].a1, m_aa);
      rb_ff    <= clamp_sub(side_ff[bdp_pkg::T_DIV_OUT].b1, m_bb);
      rprod_ff <= {{bdp_pkg::DIST_W{1'b0}}, ra_ff} * {{bdp_pkg::DIST_W{1'b0}}, rb_ff};
   end

   bdp_isqrt u_sqrt_perp (
      .clock    (clock),
      .radicand (rprod_ff),
      .root     (perp_root)
   );

   // same-pivot roots in Q16.8
   bdp_isqrt u_sqrt_a (
      .clock    (clock),
      .radicand ({{(bdp_pkg::RAD_W-bdp_pkg::DIST_W-bdp_pkg::FRAC_W){1'b0}},
                  side_ff[1].a1, {bdp_pkg::FRAC_W{1'b0}}}),
      .root     (root_a)
   );

   bdp_isqrt u_sqrt_b (
      .clock    (clock),
      .radicand ({{(bdp_pkg::RAD_W-bdp_pkg::DIST_W-bdp_pkg::FRAC_W){1'b0}},
                  side_ff[1].b1, {bdp_pkg::FRAC_W{1'b0}}}),
      .root     (root_b)
   );

   always_ff @(posedge clock) begin
      same_diff_ff <= (root_a > root_b) ? root_a[bdp_pkg::SAME_ROOT_W-1:0]
                                          - root_b[bdp_pkg::SAME_ROOT_W-1:0]
                                        : root_b[bdp_pkg::SAME_ROOT_W-1:0]
                                          - root_a[bdp_pkg::SAME_ROOT_W-1:0];
      same_sq_ff   <= {{bdp_pkg::SAME_ROOT_W{1'b0}}, same_diff_ff}
                    * {{bdp_pkg::SAME_ROOT_W{1'b0}}, same_diff_ff};
   end

   assign same_exceeds = same_sq_ff > {side_ff[bdp_pkg::T_SAME_SQ].rsq, {bdp_pkg::FRAC_W{1'b0}}};

   // side line: advance item data, drop in results at their taps
   always_comb begin
      side_in[1].same         = front_out.same;
      side_in[1].gap_zero     = (front_out.g == '0);
      side_in[1].par_neg      = sa_s[SUM_W-1] ^ sb_s[SUM_W-1];
      side_in[1].same_exceeds = 1'b0;
      side_in[1].rsq          = front_out.rsq;
      side_in[1].a1           = front_out.a1;
      side_in[1].b1           = front_out.b1;
      side_in[1].fixed        = '0;
      for (int i = 2; i <= bdp_pkg::T_ROOT; i++) begin
         side_in[i] = side_ff[i-1];
      end
      side_in[bdp_pkg::T_SAME_SQ+1].same_exceeds = same_exceeds;
      side_in[bdp_pkg::T_DIV_OUT+1].fixed        = fixed_val;
   end

   always_ff @(posedge clock) begin
      side_ff <= side_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= bdp_pkg::T_ROOT; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         valid_ff[1] <= front_out.valid;
         for (int i = 2; i <= bdp_pkg::T_ROOT; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // final verdict
   always_comb begin
      fin   = side_ff[bdp_pkg::T_ROOT];
      perp  = $signed({{(bdp_pkg::FIXED_W-bdp_pkg::ROOT_W-1){1'b0}}, perp_root, 1'b0});
      rsq_s = $signed({{(bdp_pkg::FIXED_W-bdp_pkg::DIST_W){1'b0}}, fin.rsq});
      if (fin.same) begin
         result_verdict = fin.same_exceeds ? bdp_pkg::VERDICT_EXCEEDS
                                           : bdp_pkg::VERDICT_UNDECIDED;
      end else if (fin.gap_zero) begin
         result_verdict = bdp_pkg::VERDICT_UNDECIDED;
      end else if (fin.fixed - perp > rsq_s) begin
         result_verdict = bdp_pkg::VERDICT_EXCEEDS;
      end else if (fin.fixed + perp <= rsq_s) begin
         result_verdict = bdp_pkg::VERDICT_WITHIN;
      end else begin
         result_verdict = bdp_pkg::VERDICT_UNDECIDED;
      end
   end

   assign result_valid = valid_ff[bdp_pkg::T_ROOT];

endmodule

`default_nettype wire

/* hdl/bipolar_distance_prune_unit.sv */
// ---------------------------------------------------------------------------
// bipolar_distance_prune_unit
// Pivot-table pruning: loads fill three tables, queries get a verdict of
// within, exceeds or undecided from bipolar pivot distance bounds.
// ---------------------------------------------------------------------------
//
//   channel   ports              handshake
//   -------   ----------------   ------------------------------------------
//   request   req_* fields       item taken at clock edge with start && !busy
//   response  rsp_verdict        one cycle per query, marked by rsp_strobe
//
// One item enters every cycle; busy never rises.
// A query is answered through the 12-stage quotient pipeline and the 8-stage
// root pipeline, which set the response depth.
// Loads produce no response and land in table order with later queries.
// Reset clears the valid bits only; the tables hold no value until loaded.
// The receiver cannot stall, so nothing in the pipeline ever holds.
// ---------------------------------------------------------------------------
`default_nettype none

module bipolar_distance_prune_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_op,
   input  wire logic [bdp_pkg::POINT_W-1:0]   req_point_index,
   input  wire logic [bdp_pkg::POINT_W-1:0]   req_other_point_index,
   input  wire logic [bdp_pkg::PIVOT_W-1:0]   req_pivot_index,
   input  wire logic [bdp_pkg::PIVOT_W-1:0]   req_other_pivot_index,
   input  wire logic [bdp_pkg::DIST_W-1:0]    req_load_value,
   input  wire logic [bdp_pkg::DIST_W-1:0]    req_radius_sq,
   output logic                               rsp_strobe,
   output logic [1:0]                         rsp_verdict
);

   logic                   accept;
   bdp_pkg::front_out_type front_out;
   logic                   result_valid;
   bdp_pkg::verdict_type   result_verdict;
   logic                   rsp_strobe_ff;
   bdp_pkg::verdict_type   rsp_verdict_ff;

   // the pipeline never holds, so take an item whenever one is offered
   assign busy   = 1'b0;
   assign accept = start && !busy;

   bdp_front u_front (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .op                (bdp_pkg::op_type'(req_op)),
      .point_index       (req_point_index),
      .other_point_index (req_other_point_index),
      .pivot_index       (req_pivot_index),
      .other_pivot_index (req_other_pivot_index),
      .load_value        (req_load_value),
      .radius_sq         (req_radius_sq),
      .front_out         (front_out)
   );

   bdp_math u_math (
      .clock          (clock),
      .reset          (reset),
      .front_out      (front_out),
      .result_valid   (result_valid),
      .result_verdict (result_verdict)
   );

   // register the response: strobe for exactly one cycle per query
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= result_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_verdict_ff <= result_verdict;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_verdict = rsp_verdict_ff;

`ifndef ASSERT_OFF
   a_query_answers : assert property (@(posedge clock) disable iff (reset)
      accept && req_op == bdp_pkg::OP_QUERY |-> ##(bdp_pkg::RESULT_LATENCY) rsp_strobe)
      else $error("query item produced no response");

   a_load_silent : assert property (@(posedge clock) disable iff (reset)
      accept && req_op != bdp_pkg::OP_QUERY |-> ##(bdp_pkg::RESULT_LATENCY) !rsp_strobe)
      else $error("load item produced a response");

   a_strobe_has_item : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, bdp_pkg::RESULT_LATENCY))
      else $error("response without a matching item");
`endif

endmodule

`default_nettype wire

/* tb/sv/bipolar_distance_prune_unit_test.sv */
// ---------------------------------------------------------------------------
// bipolar_distance_prune_unit_test
// Self-checking test of the pivot pruning unit: loads and queries are sent
// with random gaps, every query verdict is predicted from shadow tables and
// compared in order against the strobed responses.
// ---------------------------------------------------------------------------
`default_nettype none

module bipolar_distance_prune_unit_test;

   localparam longint unsigned SAT_LIMIT = 64'd1 << 40;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic [1:0]                    req_op;
   logic [bdp_pkg::POINT_W-1:0]   req_point_index;
   logic [bdp_pkg::POINT_W-1:0]   req_other_point_index;
   logic [bdp_pkg::PIVOT_W-1:0]   req_pivot_index;
   logic [bdp_pkg::PIVOT_W-1:0]   req_other_pivot_index;
   logic [bdp_pkg::DIST_W-1:0]    req_load_value;
   logic [bdp_pkg::DIST_W-1:0]    req_radius_sq;
   logic                          rsp_strobe;
   logic [1:0]                    rsp_verdict;

   bipolar_distance_prune_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_op                (req_op),
      .req_point_index       (req_point_index),
      .req_other_point_index (req_other_point_index),
      .req_pivot_index       (req_pivot_index),
      .req_other_pivot_index (req_other_pivot_index),
      .req_load_value        (req_load_value),
      .req_radius_sq         (req_radius_sq),
      .rsp_strobe            (rsp_strobe),
      .rsp_verdict           (rsp_verdict)
   );

   // shadow tables plus written flags, so queries never touch unloaded entries
   logic [bdp_pkg::PIVOT_W-1:0] shadow_pivot [bdp_pkg::MAX_POINTS];
   bit                 pivot_loaded [bdp_pkg::MAX_POINTS];
   logic [bdp_pkg::DIST_W-1:0]  shadow_pdist [bdp_pkg::MAX_POINTS*bdp_pkg::NUM_PIVOTS];
   bit                 pdist_loaded [bdp_pkg::MAX_POINTS*bdp_pkg::NUM_PIVOTS];
   logic [bdp_pkg::DIST_W-1:0]  shadow_gap   [bdp_pkg::NUM_PIVOTS*bdp_pkg::NUM_PIVOTS];
   bit                 gap_loaded   [bdp_pkg::NUM_PIVOTS*bdp_pkg::NUM_PIVOTS];

   bdp_pkg::verdict_type pending_verdicts[$];
   int          items_taken;
   int          items_sent;
   int          error_count;
   bit          idle_enabled;
   int          point_pool[$];

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // floored square root, bit by bit
   function automatic longint unsigned floor_root(input longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // trunc(x*y/d) with the magnitude saturated
   function automatic longint scaled_quot(input longint x, input longint y,
                                          input longint unsigned d);
      logic [127:0]    prod;
      longint unsigned mx;
      longint unsigned my;
      longint unsigned q;
      mx = (x < 0) ? -x : x;
      my = (y < 0) ? -y : y;
      prod = {64'd0, mx} * {64'd0, my};
      prod = prod / {64'd0, d};
      q = (prod > SAT_LIMIT) ? SAT_LIMIT : prod[63:0];
      return ((x < 0) != (y < 0)) ? -longint'(q) : longint'(q);
   endfunction

   function automatic bdp_pkg::verdict_type predict_verdict(input int p, input int q,
                                                            input logic [31:0] rsq);
      int              c1;
      int              c2;
      longint unsigned ra_u;
      longint unsigned rb_u;
      longint unsigned diff;
      longint          a1, a2, b1, b2, g, sa, sb, par2, ra, rb, fixed, perp, r;
      c1 = shadow_pivot[p];
      c2 = shadow_pivot[q];
      if (c1 == c2) begin
         ra_u = floor_root({16'd0, shadow_pdist[p*bdp_pkg::NUM_PIVOTS+c1], 16'd0});
         rb_u = floor_root({16'd0, shadow_pdist[q*bdp_pkg::NUM_PIVOTS+c1], 16'd0});
         diff = (ra_u > rb_u) ? ra_u - rb_u : rb_u - ra_u;
         return (diff * diff > {16'd0, rsq, 16'd0}) ? bdp_pkg::VERDICT_EXCEEDS
                                                     : bdp_pkg::VERDICT_UNDECIDED;
      end
      a1 = shadow_pdist[p*bdp_pkg::NUM_PIVOTS+c1];
      a2 = shadow_pdist[p*bdp_pkg::NUM_PIVOTS+c2];
      b1 = shadow_pdist[q*bdp_pkg::NUM_PIVOTS+c1];
      b2 = shadow_pdist[q*bdp_pkg::NUM_PIVOTS+c2];
      g  = shadow_gap[c1*bdp_pkg::NUM_PIVOTS+c2];
      if (g == 0) return bdp_pkg::VERDICT_UNDECIDED;
      sa = a1 + g - a2;
      sb = b1 + g - b2;
      par2 = scaled_quot(sa, sb, 2*g);
      ra = a1 - scaled_quot(sa, sa, 4*g);
      rb = b1 - scaled_quot(sb, sb, 4*g);
      if (ra < 0) ra = 0;
      if (rb < 0) rb = 0;
      fixed = a1 + b1 - par2;
      perp = 2 * longint'(floor_root(longint'(ra) * longint'(rb)));
      r = {32'd0, rsq};
      if (fixed - perp > r) return bdp_pkg::VERDICT_EXCEEDS;
      if (fixed + perp <= r) return bdp_pkg::VERDICT_WITHIN;
      return bdp_pkg::VERDICT_UNDECIDED;
   endfunction

   // take the item at the accepting edge: update the shadow tables, or
   // queue the predicted verdict for a query
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         items_taken++;
         case (bdp_pkg::op_type'(req_op))
            bdp_pkg::OP_SET_PIVOT: begin
               shadow_pivot[req_point_index] = req_pivot_index;
               pivot_loaded[req_point_index] = 1'b1;
            end
            bdp_pkg::OP_SET_POINT_DIST: begin
               shadow_pdist[req_point_index*bdp_pkg::NUM_PIVOTS+req_pivot_index] =
                  req_load_value;
               pdist_loaded[req_point_index*bdp_pkg::NUM_PIVOTS+req_pivot_index] = 1'b1;
            end
            bdp_pkg::OP_SET_PIVOT_DIST: begin
               shadow_gap[req_pivot_index*bdp_pkg::NUM_PIVOTS+req_other_pivot_index] =
                  req_load_value;
               gap_loaded[req_pivot_index*bdp_pkg::NUM_PIVOTS+req_other_pivot_index] = 1'b1;
            end
            bdp_pkg::OP_QUERY: begin
               pending_verdicts.insert(pending_verdicts.size(),
                                       predict_verdict(req_point_index,
                                                       req_other_point_index,
                                                       req_radius_sq));
            end
            default: begin
            end
         endcase
      end
   end

   // compare each strobed verdict with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_verdicts.size() == 0) begin
            $error("unexpected response: verdict actual %0d", rsp_verdict);
            error_count++;
         end else begin
            if (rsp_verdict !== pending_verdicts[0]) begin
               $error("verdict: expected %0d actual %0d",
                      pending_verdicts[0], rsp_verdict);
               error_count++;
            end
            void'(pending_verdicts.pop_front());
         end
      end
   end

   // drop start and hold off for a random gap
   task automatic hold_off(input int cycles);
      start = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // drive one item (called at a falling edge) and wait until it is taken;
   // fields unused by the op carry random junk
   task automatic send_item(input bdp_pkg::op_type op, input int pt, input int pt2,
                            input int pv, input int pv2,
                            input logic [31:0] val, input logic [31:0] rsq);
      int taken_before;
      taken_before = items_taken;
      req_op                = op;
      req_point_index       = pt;
      req_other_point_index = pt2;
      req_pivot_index       = pv;
      req_other_pivot_index = pv2;
      req_load_value        = val;
      req_radius_sq         = rsq;
      start                 = 1'b1;
      do @(negedge clock); while (items_taken == taken_before);
      items_sent++;
      if (idle_enabled && $urandom_range(0, 99) < 9)
         hold_off($urandom_range(1, 3));
   endtask

   function automatic logic [31:0] pick_distance();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $urandom >> $urandom_range(0, 31);
         2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1;
         default: return $urandom_range(0, 32'h00FF_FFFF);
      endcase
   endfunction

   task automatic load_pivot(input int pt, input int pv);
      send_item(bdp_pkg::OP_SET_PIVOT, pt, $urandom_range(0, 1023), pv,
                $urandom_range(0, 15), $urandom, $urandom);
   endtask

   task automatic load_point_dist(input int pt, input int pv, input logic [31:0] v);
      send_item(bdp_pkg::OP_SET_POINT_DIST, pt, $urandom_range(0, 1023), pv,
                $urandom_range(0, 15), v, $urandom);
   endtask

   task automatic load_gap(input int pv, input int pv2, input logic [31:0] v);
      send_item(bdp_pkg::OP_SET_PIVOT_DIST, $urandom_range(0, 1023),
                $urandom_range(0, 1023), pv, pv2, v, $urandom);
   endtask

   task automatic send_query(input int p, input int q, input logic [31:0] rsq);
      send_item(bdp_pkg::OP_QUERY, p, q, $urandom_range(0, 15), $urandom_range(0, 15),
                $urandom, rsq);
   endtask

   // load whatever the query will read and has never been written, then query
   task automatic query_loaded(input int p, input int q, input logic [31:0] rsq);
      int c1;
      int c2;
      if (!pivot_loaded[p]) load_pivot(p, $urandom_range(0, 99) < 40 ?
                                          $urandom_range(0, 1) : $urandom_range(0, 15));
      if (!pivot_loaded[q]) load_pivot(q, $urandom_range(0, 99) < 40 ?
                                          $urandom_range(0, 1) : $urandom_range(0, 15));
      c1 = shadow_pivot[p];
      c2 = shadow_pivot[q];
      if (!pdist_loaded[p*bdp_pkg::NUM_PIVOTS+c1]) load_point_dist(p, c1, pick_distance());
      if (!pdist_loaded[p*bdp_pkg::NUM_PIVOTS+c2]) load_point_dist(p, c2, pick_distance());
      if (!pdist_loaded[q*bdp_pkg::NUM_PIVOTS+c1]) load_point_dist(q, c1, pick_distance());
      if (!pdist_loaded[q*bdp_pkg::NUM_PIVOTS+c2]) load_point_dist(q, c2, pick_distance());
      if (c1 != c2 && !gap_loaded[c1*bdp_pkg::NUM_PIVOTS+c2])
         load_gap(c1, c2, $urandom_range(0, 9) == 0 ? 32'd0 : pick_distance());
      send_query(p, q, rsq);
   endtask

   // extreme points and extreme values, same pivot
   task automatic test_same_pivot_extremes();
      load_pivot(0, 0);
      load_pivot(1023, 0);
      load_point_dist(0, 0, 32'd0);
      load_point_dist(1023, 0, 32'hFFFF_FFFF);
      send_query(0, 1023, 32'd0);
      send_query(1023, 0, 32'hFFFF_FFFF);
      send_query(0, 0, 32'd0);
   endtask

   // different pivots: a zero gap, then a clean bounding case
   task automatic test_different_pivots();
      load_pivot(5, 15);
      load_point_dist(5, 15, 32'h0001_0000);
      load_point_dist(5, 0, 32'h0004_0000);
      load_point_dist(0, 15, 32'h0009_0000);
      load_point_dist(1023, 15, 32'hFFFF_FFFF);
      load_gap(0, 15, 32'd0);
      send_query(0, 5, 32'h0010_0000);
      load_gap(0, 15, 32'h0004_0000);
      load_gap(15, 0, 32'hFFFF_FFFF);
      send_query(0, 5, 32'h0000_1000);
      send_query(0, 5, 32'h0020_0000);
      send_query(1023, 5, 32'hFFFF_FFFF);
      send_query(5, 1023, 32'd0);
   endtask

   // stop sending until the pipeline has drained
   task automatic test_drain_pause();
      start = 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clock);
      send_query(0, 1023, $urandom);
   endtask

   task automatic test_random_traffic();
      int n;
      int p;
      int q;
      int pv;
      for (n = 0; n < 40; n++) point_pool.insert(point_pool.size(), $urandom_range(0, 1023));
      point_pool.insert(point_pool.size(), 0);
      point_pool.insert(point_pool.size(), 1023);
      n = 0;
      while (items_sent < 1750) begin
         // one long stretch without sender gaps
         idle_enabled = !(n >= 300 && n < 500);
         p = point_pool[$urandom_range(0, point_pool.size() - 1)];
         q = point_pool[$urandom_range(0, point_pool.size() - 1)];
         case ($urandom_range(0, 9))
            0: begin
               // rewrite an entry that queries will read
               pv = $urandom_range(0, 15);
               case ($urandom_range(0, 2))
                  0: load_pivot(p, pv);
                  1: load_point_dist(p, pv, pick_distance());
                  default: load_gap(pv, $urandom_range(0, 15),
                                    $urandom_range(0, 3) == 0 ? 32'd0 : pick_distance());
               endcase
            end
            1: load_point_dist($urandom_range(0, 1023), $urandom_range(0, 15), $urandom);
            default: query_loaded(p, q, $urandom_range(0, 1) ? pick_distance()
                                                              : $urandom);
         endcase
         n++;
      end
      idle_enabled = 1'b1;
   endtask

   initial begin
      start                 = 1'b0;
      reset                 = 1'b1;
      req_op                = '0;
      req_point_index       = '0;
      req_other_point_index = '0;
      req_pivot_index       = '0;
      req_other_pivot_index = '0;
      req_load_value        = '0;
      req_radius_sq         = '0;
      items_taken           = 0;
      items_sent            = 0;
      error_count           = 0;
      idle_enabled          = 1'b1;
      repeat (9) @(negedge clock);
      reset = 1'b0;
      test_same_pivot_extremes();
      test_different_pivots();
      test_drain_pause();
      test_random_traffic();
      start = 1'b0;
      // drain: wait for outstanding verdicts, then let the pipeline empty
      while (pending_verdicts.size() != 0) @(negedge clock);
      repeat (bdp_pkg::RESULT_LATENCY + 10) @(negedge clock);
      if (error_count == 0 && pending_verdicts.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // guard against a hung run
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
hdl/bdp_pkg.sv
hdl/bdp_divider.sv
hdl/bdp_isqrt.sv
hdl/bdp_front.sv
hdl/bdp_math.sv
hdl/bipolar_distance_prune_unit.sv
tb/sv/bipolar_distance_prune_unit_test.sv
